>>> design/tct_pkg.sv
// ----------------------------------------------------------------------------
// tct_pkg
// Types and constants shared by the teletype text console.
// ----------------------------------------------------------------------------
package tct_pkg;

   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;

   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_RETURN  = 8'd13;
   localparam logic [7:0] CH_TAB     = 8'd9;
   localparam logic [7:0] CH_BLANK   = 8'd32;
   localparam int         TAB_STEP   = 4;
   localparam int         TAB_SHIFT  = $clog2(TAB_STEP);

   localparam logic [7:0] FILL_ATTRIBUTE_RESET = 8'd7;

   typedef enum logic [1:0] {
      OP_PUT         = 2'd0,
      OP_MOVE_CURSOR = 2'd1,
      OP_READ        = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCROLL
   } state_type;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] char_code;
      logic [7:0] attribute;
      logic [6:0] column;
      logic [4:0] row;
   } req_type;

   typedef struct packed {
      logic [6:0] cursor_column;
      logic [4:0] cursor_row;
      logic       scrolled;
      logic [7:0] read_char;
      logic [7:0] read_attribute;
   } rsp_type;

endpackage

>>> design/text_console_teletype_unit.sv
// ----------------------------------------------------------------------------
// text_console_teletype_unit
// Teletype console over a single-port-read, single-port-write cell memory.
// ----------------------------------------------------------------------------
//  Channel  Ports                                   Direction
//  request  req_valid, req_stall, req_data          in
//  response rsp_valid, rsp_stall, rsp_data          out
//  config   csr_write_enable, csr_write_data        in
//
// Puts that do not scroll, cursor moves, unused operations and reads outside
// the screen have their response registered as the word is taken; reads inside
// the screen pass through the memory read and the read state first. A scroll
// is one memory pass copying each cell up one row and filling the bottom row.
// After reset a clearing pass blanks the memory; no request word is taken
// until it ends. A word is taken only while the response register is empty
// or being emptied in the same cycle.
module text_console_teletype_unit #(
   parameter int COLUMNS = tct_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tct_pkg::ROWS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tct_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tct_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic [7:0]       csr_write_data
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int NW    = $clog2(CELLS + 1);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);

   tct_pkg::state_type state_ff, state_in;
   logic [NW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]      cursor_col_ff, cursor_col_in;
   logic [RW-1:0]      cursor_row_ff, cursor_row_in;
   logic [7:0]         fill_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   tct_pkg::rsp_type   rsp_ff, rsp_in;

   logic [15:0]        cell_mem_ff [CELLS];
   logic [15:0]        rd_data_ff;
   logic               mem_we, mem_re;
   logic [AW-1:0]      mem_waddr, mem_raddr;
   logic [15:0]        mem_wdata;

   logic               accept;
   logic [CW-1:0]      col_nx;
   logic [RW-1:0]      row_nx;
   logic               scroll_go;
   logic [CW:0]        tab_x;
   logic [AW-1:0]      cursor_idx, req_idx;
   logic [AW-1:0]      wr_ptr;

   assign req_stall = !(state_ff == tct_pkg::ST_IDLE && (!rsp_valid_ff || !rsp_stall));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign tab_x = {({1'b0, cursor_col_ff[CW-1:tct_pkg::TAB_SHIFT]} + (CW-1)'(1)),
                   {tct_pkg::TAB_SHIFT{1'b0}}};
   assign cursor_idx = AW'(AW'(cursor_row_ff) * AW'(COLUMNS)) + AW'(cursor_col_ff);
   assign req_idx    = AW'(AW'(req_data.row) * AW'(COLUMNS)) + AW'(req_data.column);
   assign wr_ptr     = AW'(cnt_ff - NW'(1));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem_ff[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= cell_mem_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tct_pkg::ST_CLEAR;
         cnt_ff        <= '0;
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
         fill_ff       <= tct_pkg::FILL_ATTRIBUTE_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_enable) begin
            fill_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_waddr     = cursor_idx;
      mem_wdata     = {req_data.char_code, req_data.attribute};
      mem_re        = 1'b0;
      mem_raddr     = req_idx;
      col_nx        = cursor_col_ff;
      row_nx        = cursor_row_ff;
      scroll_go     = 1'b0;

      unique case (state_ff)
         tct_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[AW-1:0];
            mem_wdata = {tct_pkg::CH_BLANK, 8'h00};
            cnt_in    = cnt_ff + NW'(1);
            if (cnt_ff == NW'(CELLS - 1)) begin
               state_in = tct_pkg::ST_IDLE;
            end
         end
         tct_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_data.op)
                  tct_pkg::OP_PUT: begin
                     if (req_data.char_code == tct_pkg::CH_NEWLINE) begin
                        col_nx = '0;
                        if (int'(cursor_row_ff) >= ROWS - 1) begin
                           scroll_go = 1'b1;
                        end else begin
                           row_nx = cursor_row_ff + RW'(1);
                        end
                     end else if (req_data.char_code == tct_pkg::CH_RETURN) begin
                        col_nx = '0;
                     end else if (req_data.char_code == tct_pkg::CH_TAB) begin
                        col_nx = (int'(tab_x) < COLUMNS) ? CW'(tab_x) : CW'(COLUMNS - 1);
                     end else begin
                        mem_we = 1'b1;
                        if (int'(cursor_col_ff) >= COLUMNS - 1) begin
                           col_nx = '0;
                           if (int'(cursor_row_ff) >= ROWS - 1) begin
                              scroll_go = 1'b1;
                           end else begin
                              row_nx = cursor_row_ff + RW'(1);
                           end
                        end else begin
                           col_nx = cursor_col_ff + CW'(1);
                        end
                     end
                  end
                  tct_pkg::OP_MOVE_CURSOR: begin
                     col_nx = (int'(req_data.column) < COLUMNS) ?
                              CW'(req_data.column) : CW'(COLUMNS - 1);
                     row_nx = (int'(req_data.row) < ROWS) ?
                              RW'(req_data.row) : RW'(ROWS - 1);
                  end
                  default: begin
                  end
               endcase
               cursor_col_in = col_nx;
               cursor_row_in = row_nx;
               if (req_data.op == tct_pkg::OP_READ &&
                   int'(req_data.column) < COLUMNS && int'(req_data.row) < ROWS) begin
                  mem_re   = 1'b1;
                  state_in = tct_pkg::ST_READ;
               end else if (scroll_go) begin
                  cnt_in   = '0;
                  state_in = tct_pkg::ST_SCROLL;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{cursor_column: 7'(col_nx), cursor_row: 5'(row_nx),
                                   scrolled: 1'b0, read_char: 8'h00,
                                   read_attribute: 8'h00};
               end
            end
         end
         tct_pkg::ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{cursor_column: 7'(cursor_col_ff), cursor_row: 5'(cursor_row_ff),
                             scrolled: 1'b0, read_char: rd_data_ff[15:8],
                             read_attribute: rd_data_ff[7:0]};
            state_in     = tct_pkg::ST_IDLE;
         end
         tct_pkg::ST_SCROLL: begin
            // Read runs one cell ahead of the write that uses its data.
            if (cnt_ff < NW'(CELLS - COLUMNS)) begin
               mem_re    = 1'b1;
               mem_raddr = AW'(cnt_ff) + AW'(COLUMNS);
            end
            if (cnt_ff != '0) begin
               mem_we    = 1'b1;
               mem_waddr = wr_ptr;
               mem_wdata = (int'(wr_ptr) < CELLS - COLUMNS) ? rd_data_ff : {8'h00, fill_ff};
            end
            cnt_in = cnt_ff + NW'(1);
            if (cnt_ff == NW'(CELLS)) begin
               state_in     = tct_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in       = '{cursor_column: 7'(cursor_col_ff),
                                cursor_row: 5'(cursor_row_ff),
                                scrolled: 1'b1, read_char: 8'h00, read_attribute: 8'h00};
            end
         end
         default: begin
            state_in = tct_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the teletype text console word by word against a behavioural model
// of the cursor, the cell store and the scroll, with random idling on both
// channels and several fill attribute settings.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int         COLUMNS       = tct_pkg::COLUMNS_DEFAULT;
   localparam int         ROWS          = tct_pkg::ROWS_DEFAULT;
   localparam int         CELLS         = ROWS * COLUMNS;
   localparam int         SETTLE_CYCLES = CELLS + 8;
   localparam int         CLOCK_PERIOD  = 10;
   localparam int         REQ_BITS      = $bits(tct_pkg::req_type);
   localparam logic [1:0] OP_UNUSED     = 2'd3;

   logic             clock            = 1'b0;
   logic             reset            = 1'b1;
   logic             req_valid        = 1'b0;
   logic             req_stall;
   tct_pkg::req_type req_data         = '0;
   logic             rsp_valid;
   logic             rsp_stall        = 1'b0;
   tct_pkg::rsp_type rsp_data;
   logic             csr_write_enable = 1'b0;
   logic [7:0]       csr_write_data   = '0;

   logic [7:0] screen_char [CELLS];
   logic [7:0] screen_attr [CELLS];
   int         model_col    = 0;
   int         model_row    = 0;
   logic [7:0] model_fill   = tct_pkg::FILL_ATTRIBUTE_RESET;

   tct_pkg::rsp_type expected_words [$];
   tct_pkg::rsp_type oldest_word;
   int               error_count  = 0;
   int               items_sent   = 0;
   int               scrolls_left = 1000;
   bit               idling_on    = 1'b1;

   text_console_teletype_unit #(.COLUMNS(COLUMNS), .ROWS(ROWS)) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic tct_pkg::req_type random_word();
      tct_pkg::req_type w;
      w = REQ_BITS'($urandom());
      return w;
   endfunction

   // Updates the console model with one word and returns the response it should give.
   function automatic tct_pkg::rsp_type console_apply(input tct_pkg::req_type word);
      tct_pkg::rsp_type res;
      bit               scroll;
      int               stop;
      res    = '0;
      scroll = 1'b0;
      case (word.op)
         tct_pkg::OP_PUT: begin
            if (word.char_code == tct_pkg::CH_NEWLINE) begin
               model_col = 0;
               if (model_row >= ROWS - 1) scroll = 1'b1;
               else model_row++;
            end else if (word.char_code == tct_pkg::CH_RETURN) begin
               model_col = 0;
            end else if (word.char_code == tct_pkg::CH_TAB) begin
               stop      = (model_col / tct_pkg::TAB_STEP + 1) * tct_pkg::TAB_STEP;
               model_col = (stop < COLUMNS) ? stop : COLUMNS - 1;
            end else begin
               screen_char[model_row * COLUMNS + model_col] = word.char_code;
               screen_attr[model_row * COLUMNS + model_col] = word.attribute;
               if (model_col >= COLUMNS - 1) begin
                  model_col = 0;
                  if (model_row >= ROWS - 1) scroll = 1'b1;
                  else model_row++;
               end else begin
                  model_col++;
               end
            end
            if (scroll) begin
               for (int i = 0; i < CELLS - COLUMNS; i++) begin
                  screen_char[i] = screen_char[i + COLUMNS];
                  screen_attr[i] = screen_attr[i + COLUMNS];
               end
               for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
                  screen_char[i] = 8'h00;
                  screen_attr[i] = model_fill;
               end
               if (scrolls_left > 0) scrolls_left--;
            end
            res.scrolled = scroll;
         end
         tct_pkg::OP_MOVE_CURSOR: begin
            model_col = (word.column < COLUMNS) ? word.column : COLUMNS - 1;
            model_row = (word.row < ROWS) ? word.row : ROWS - 1;
         end
         tct_pkg::OP_READ: begin
            if (word.column < COLUMNS && word.row < ROWS) begin
               res.read_char      = screen_char[word.row * COLUMNS + word.column];
               res.read_attribute = screen_attr[word.row * COLUMNS + word.column];
            end
         end
         default: ;
      endcase
      res.cursor_column = 7'(model_col);
      res.cursor_row    = 5'(model_row);
      return res;
   endfunction

   task automatic send_word(input tct_pkg::req_type word);
      int gap;
      gap = idling_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= word;
      do @(posedge clock); while (req_stall !== 1'b0);
      expected_words.push_back(console_apply(word));
      items_sent++;
   endtask

   task automatic put_char(input logic [7:0] ch, input logic [7:0] attr);
      tct_pkg::req_type w;
      bit               would_scroll;
      w             = random_word();
      w.op          = tct_pkg::OP_PUT;
      w.char_code   = ch;
      w.attribute   = attr;
      would_scroll  = model_row >= ROWS - 1 && (ch == tct_pkg::CH_NEWLINE ||
                      (ch != tct_pkg::CH_RETURN && ch != tct_pkg::CH_TAB &&
                       model_col >= COLUMNS - 1));
      // Scrolls are slow, so once the allowance is spent the word becomes a return.
      if (would_scroll && scrolls_left == 0) w.char_code = tct_pkg::CH_RETURN;
      send_word(w);
   endtask

   task automatic move_cursor(input int col, input int row);
      tct_pkg::req_type w;
      w        = random_word();
      w.op     = tct_pkg::OP_MOVE_CURSOR;
      w.column = 7'(col);
      w.row    = 5'(row);
      send_word(w);
   endtask

   task automatic read_cell(input int col, input int row);
      tct_pkg::req_type w;
      w        = random_word();
      w.op     = tct_pkg::OP_READ;
      w.column = 7'(col);
      w.row    = 5'(row);
      send_word(w);
   endtask

   task automatic send_unused();
      tct_pkg::req_type w;
      w    = random_word();
      w.op = OP_UNUSED;
      send_word(w);
   endtask

   task automatic wait_console_idle();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   task automatic test_reset_contents();
      read_cell(0, 0);
      read_cell(COLUMNS - 1, ROWS - 1);
      read_cell(COLUMNS, 0);
      read_cell(0, ROWS);
      read_cell(127, 31);
      send_unused();
   endtask

   task automatic test_control_characters();
      put_char(8'hFF, 8'hFF);
      put_char(8'h00, 8'h00);
      put_char(tct_pkg::CH_TAB, 8'h00);
      put_char(tct_pkg::CH_RETURN, 8'h00);
      put_char(tct_pkg::CH_NEWLINE, 8'h00);
      read_cell(0, 0);
      read_cell(1, 0);
   endtask

   task automatic test_wrap_and_scroll();
      move_cursor(COLUMNS - 1, 0);
      put_char(8'h41, 8'h1E);
      move_cursor(COLUMNS - 1, ROWS - 1);
      put_char(8'h5A, 8'h81);
      read_cell(COLUMNS - 1, ROWS - 2);
      read_cell(0, ROWS - 1);
      put_char(tct_pkg::CH_NEWLINE, 8'h00);
   endtask

   task automatic test_cursor_limits();
      move_cursor(127, 31);
      move_cursor(COLUMNS - 3, 2);
      put_char(tct_pkg::CH_TAB, 8'h00);
      put_char(tct_pkg::CH_TAB, 8'h00);
   endtask

   task automatic test_random_traffic();
      logic [7:0] fill_values [5];
      int         target;
      int         pick;
      int         back;
      fill_values    = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h5A};
      fill_values[2] = 8'($urandom());
      fill_values[3] = 8'($urandom());
      foreach (fill_values[i]) begin
         wait_console_idle();
         csr_write_enable <= 1'b1;
         csr_write_data   <= fill_values[i];
         @(posedge clock);
         csr_write_enable <= 1'b0;
         model_fill   = fill_values[i];
         scrolls_left = 25;
         move_cursor($urandom_range(0, COLUMNS - 1), ROWS - 1);
         put_char(tct_pkg::CH_NEWLINE, 8'($urandom()));
         read_cell($urandom_range(0, COLUMNS - 1), ROWS - 1);
         target = items_sent + 300;
         while (items_sent < target) begin
            if ($urandom_range(0, 39) == 0) idling_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  case ($urandom_range(0, 3))
                     0: move_cursor($urandom_range(COLUMNS - 6, COLUMNS - 1),
                                    $urandom_range(0, ROWS - 1));
                     1: move_cursor($urandom_range(0, COLUMNS - 1), ROWS - 1);
                     2: move_cursor($urandom_range(0, 127), $urandom_range(0, 31));
                     default: ;
                  endcase
                  repeat ($urandom_range(1, 12)) begin
                     pick = $urandom_range(0, 19);
                     put_char((pick == 0) ? tct_pkg::CH_NEWLINE :
                              (pick == 1) ? tct_pkg::CH_RETURN :
                              (pick == 2) ? tct_pkg::CH_TAB : 8'($urandom()),
                              8'($urandom()));
                  end
                  repeat ($urandom_range(1, 3)) begin
                     back = $urandom_range(0, 3);
                     read_cell((model_col >= back) ? model_col - back : 0, model_row);
                  end
               end
               4, 5: read_cell($urandom_range(0, 127), $urandom_range(0, 31));
               6: read_cell($urandom_range(0, COLUMNS - 1),
                            (model_row > 0) ? model_row - 1 : 0);
               7: move_cursor($urandom_range(0, 127), $urandom_range(0, 31));
               8: put_char(8'($urandom()), 8'($urandom()));
               default: send_unused();
            endcase
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_words.size() == 0) begin
            $error("response word with no expectation waiting");
            error_count++;
         end else begin
            oldest_word = expected_words.pop_front();
            check_field("cursor_column", 8'(oldest_word.cursor_column),
                        8'(rsp_data.cursor_column));
            check_field("cursor_row", 8'(oldest_word.cursor_row),
                        8'(rsp_data.cursor_row));
            check_field("scrolled", 8'(oldest_word.scrolled), 8'(rsp_data.scrolled));
            check_field("read_char", oldest_word.read_char, rsp_data.read_char);
            check_field("read_attribute", oldest_word.read_attribute,
                        rsp_data.read_attribute);
         end
      end
   end

   initial begin
      int n;
      @(posedge clock);
      forever begin
         n = idling_on ? pick_gap() : 0;
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      for (int i = 0; i < CELLS; i++) begin
         screen_char[i] = tct_pkg::CH_BLANK;
         screen_attr[i] = 8'h00;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_contents();
      test_control_characters();
      test_wrap_and_scroll();
      test_cursor_limits();
      test_random_traffic();
      wait_console_idle();
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/tct_pkg.sv
design/text_console_teletype_unit.sv
verif/tb_top.sv
